// ===== sv/udrb_pkg.sv =====
// shared constants and types for the dual uart ring buffer
package udrb_pkg;

    // slots per ring, one always kept free to tell full from empty
    localparam int SLOTS  = 64;
    localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BYTE_W = 8;

    // byte that terminates a host string
    localparam logic [BYTE_W-1:0] END_MARK = 8'h00;

    typedef enum logic [1:0] {
        REQ_RX    = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_TXRDY = 2'd3
    } t_req;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [BYTE_W-1:0] t_byte;

    // pointer update request into a ring controller
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_cmd;

    // pointer state out of a ring controller
    typedef struct packed {
        t_ptr head;
        t_ptr tail;
        logic empty;
        logic full;
    } t_ring_stat;

endpackage

// ===== sv/udrb_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/udrb_ring.sv =====
// head and tail pointers of one circular buffer with full and empty flags
module udrb_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  udrb_pkg::t_ring_cmd   i_cmd,
    output udrb_pkg::t_ring_stat  o_stat
);

    import udrb_pkg::*;

    t_ptr r_head;
    t_ptr r_tail;
    t_ptr n_head;
    t_ptr n_tail;

    function automatic t_ptr next_slot(t_ptr i);
        if (i == t_ptr'(SLOTS - 1)) begin
            return '0;
        end else begin
            return i + t_ptr'(1);
        end
    endfunction

    always_comb begin
        n_head = i_cmd.push ? next_slot(r_head) : r_head;
        n_tail = i_cmd.pop  ? next_slot(r_tail) : r_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    assign o_stat.head  = r_head;
    assign o_stat.tail  = r_tail;
    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.full  = (next_slot(r_head) == r_tail);

    // never push into a full ring or pop an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_stat.full) else $error("push into full ring");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_stat.empty) else $error("pop from empty ring");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_stat.full && o_stat.empty)) else $error("ring full and empty at once");

endmodule

// ===== sv/uart_dual_ring_buffer_top.sv =====
// top level of the dual uart ring buffer: request decode, rings, byte memories, result register
//
// Two circular byte fifos of udrb_pkg::SLOTS slots each (one slot always left free, so
// each holds SLOTS-1 bytes) sit between a serial line and a host. Each input beat is one
// event, its kind in tuser: line byte received, host read, host write byte, transmitter
// ready. Every beat gives exactly one result beat. Received bytes go into the receive
// fifo or are dropped and flagged when it is full; each receive event toggles the
// activity led (high after reset). A host read pops a byte, or reports empty with a zero
// byte. Host writes fill the transmit fifo; once it is full the rest of the string is
// thrown away until a zero byte, which is never stored and enables the transmit
// interrupt. A transmitter-ready event while enabled hands out one byte, or clears the
// enable when the transmit fifo is empty. All pointer and flag updates happen at the
// input beat; the bytes themselves live in two synchronous rams with a registered read
// port, and a result passes the pending stage and then the output register. The block
// sustains one beat per cycle as long as the result side takes beats, since a beat
// finishes its ram access in the cycle after acceptance while the next one enters. No
// clearing pass is needed after reset: a slot is only ever read after it has been written.
module uart_dual_ring_buffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // read_byte[7:0], read_empty[8], send_valid[9],
                                     // send_byte[17:10], tx_irq_enabled[18],
                                     // activity_led[19], rx_dropped[20], zero[23:21]
);

    import udrb_pkg::*;

    // what a beat carries from acceptance to the cycle its ram data arrives
    typedef struct packed {
        logic sel_rx;      // read_byte comes from the receive ram
        logic sel_tx;      // send_byte comes from the transmit ram
        logic read_empty;
        logic tx_en;
        logic led;
        logic dropped;
    } t_pend;

    // result beat, first field in the high bits
    typedef struct packed {
        logic  dropped;
        logic  led;
        logic  tx_irq;
        t_byte send_byte;
        logic  send_valid;
        logic  read_empty;
        t_byte read_byte;
    } t_result;

    t_req       w_req;
    logic       w_acc;
    logic       w_move;

    t_ring_cmd  w_rx_cmd;
    t_ring_cmd  w_tx_cmd;
    t_ring_stat w_rx_stat;
    t_ring_stat w_tx_stat;
    t_byte      w_rx_rdata;
    t_byte      w_tx_rdata;

    // flags and led
    logic       r_led;
    logic       n_led;
    logic       r_tx_en;
    logic       n_tx_en;
    logic       r_drop_rest;
    logic       n_drop_rest;

    // pending stage and output register
    logic       r_pend_valid;
    t_pend      r_pend;
    t_pend      n_pend;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    assign w_req      = t_req'(i_s_tuser);
    assign w_move     = r_pend_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_pend_valid || w_move;
    assign w_acc      = i_s_tvalid && o_s_tready;

    // event decode, all pointer moves decided here
    always_comb begin
        w_rx_cmd    = '0;
        w_tx_cmd    = '0;
        n_led       = r_led;
        n_tx_en     = r_tx_en;
        n_drop_rest = r_drop_rest;
        n_pend      = '0;
        unique case (w_req)
            REQ_RX: begin
                n_led = !r_led;
                if (w_rx_stat.full) begin
                    n_pend.dropped = 1'b1;
                end else begin
                    w_rx_cmd.push = w_acc;
                end
            end
            REQ_READ: begin
                if (w_rx_stat.empty) begin
                    n_pend.read_empty = 1'b1;
                end else begin
                    w_rx_cmd.pop  = w_acc;
                    n_pend.sel_rx = 1'b1;
                end
            end
            REQ_WRITE: begin
                if (i_s_tdata == END_MARK) begin
                    n_drop_rest = 1'b0;
                    n_tx_en     = 1'b1;
                end else if (!r_drop_rest) begin
                    if (w_tx_stat.full) begin
                        n_drop_rest = 1'b1;
                    end else begin
                        w_tx_cmd.push = w_acc;
                    end
                end
            end
            REQ_TXRDY: begin
                if (r_tx_en) begin
                    if (w_tx_stat.empty) begin
                        n_tx_en = 1'b0;
                    end else begin
                        w_tx_cmd.pop  = w_acc;
                        n_pend.sel_tx = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_pend.tx_en = n_tx_en;
        n_pend.led   = n_led;
    end

    // rings
    udrb_ring u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rx_cmd),
        .o_stat  (w_rx_stat)
    );

    udrb_ring u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_tx_cmd),
        .o_stat  (w_tx_stat)
    );

    // byte memories, read only on a pop so the read data holds while the result waits
    udrb_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_cmd.push),
        .i_waddr (w_rx_stat.head),
        .i_wdata (i_s_tdata),
        .i_re    (w_rx_cmd.pop),
        .i_raddr (w_rx_stat.tail),
        .o_rdata (w_rx_rdata)
    );

    udrb_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_cmd.push),
        .i_waddr (w_tx_stat.head),
        .i_wdata (i_s_tdata),
        .i_re    (w_tx_cmd.pop),
        .i_raddr (w_tx_stat.tail),
        .o_rdata (w_tx_rdata)
    );

    // assemble the result from the pending beat and the ram outputs
    always_comb begin
        n_out.read_byte  = r_pend.sel_rx ? w_rx_rdata : '0;
        n_out.read_empty = r_pend.read_empty;
        n_out.send_valid = r_pend.sel_tx;
        n_out.send_byte  = r_pend.sel_tx ? w_tx_rdata : '0;
        n_out.tx_irq     = r_pend.tx_en;
        n_out.led        = r_pend.led;
        n_out.dropped    = r_pend.dropped;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led        <= 1'b1;
            r_tx_en      <= 1'b0;
            r_drop_rest  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_led       <= n_led;
                r_tx_en     <= n_tx_en;
                r_drop_rest <= n_drop_rest;
            end
            if (w_acc) begin
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend <= n_pend;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

    // a beat never reads both rams
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !(r_pend.sel_rx && r_pend.sel_tx))
        else $error("pending beat selects both rams");

    // a byte is only sent while the transmit interrupt is enabled
    a_send_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_valid) |-> r_out.tx_irq)
        else $error("byte sent with transmit interrupt disabled");

    // the led moves only on an accepted receive event
    a_led_rx_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_led != $past(r_led)) |-> $past(w_acc && (w_req == REQ_RX)))
        else $error("led toggled without a receive event");

    // an accepted beat always reaches the pending stage
    a_pend_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_pend_valid)
        else $error("accepted beat lost");

endmodule

// ===== test/udrb_checker.sv =====
// checker for the dual uart ring buffer: predicts every result beat and compares it
`timescale 1ns / 1ps

module udrb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // read_byte, read_empty, send_valid, send_byte,
                                     // tx_irq_enabled, activity_led, rx_dropped, zero
    output int          o_fail_count,
    output int          o_pending
);

    import udrb_pkg::*;

    // same layout as the result tdata, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        logic       dropped;
        logic       led;
        logic       irq;
        t_byte      sent_byte;
        logic       sent;
        logic       empty;
        t_byte      rd_byte;
    } t_check_result;

    t_check_result results_due[$];

    t_byte rx_mem [SLOTS];
    t_byte tx_mem [SLOTS];
    t_ptr  rx_wr, rx_rd, tx_wr, tx_rd;
    logic  irq_en, discard, led;
    int    fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_ptr bump(t_ptr p);
        return (p == t_ptr'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // advance both rings by one event and give the result it produces
    function automatic t_check_result step_rings(t_req kind, t_byte data);
        t_check_result r;
        r = '0;
        case (kind)
            REQ_RX: begin
                led = ~led;
                if (bump(rx_wr) == rx_rd) begin
                    r.dropped = 1'b1;
                end else begin
                    rx_mem[rx_wr] = data;
                    rx_wr = bump(rx_wr);
                end
            end
            REQ_READ: begin
                if (rx_rd != rx_wr) begin
                    r.rd_byte = rx_mem[rx_rd];
                    rx_rd = bump(rx_rd);
                end else begin
                    r.empty = 1'b1;
                end
            end
            REQ_WRITE: begin
                if (data == END_MARK) begin
                    discard = 1'b0;
                    irq_en  = 1'b1;
                end else if (!discard) begin
                    if (bump(tx_wr) == tx_rd) begin
                        discard = 1'b1;
                    end else begin
                        tx_mem[tx_wr] = data;
                        tx_wr = bump(tx_wr);
                    end
                end
            end
            default: begin
                if (irq_en) begin
                    if (tx_rd == tx_wr) begin
                        irq_en = 1'b0;
                    end else begin
                        r.sent_byte = tx_mem[tx_rd];
                        r.sent      = 1'b1;
                        tx_rd = bump(tx_rd);
                    end
                end
            end
        endcase
        r.irq = irq_en;
        r.led = led;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_check_result want, got;
        if (!i_rst_n) begin
            rx_wr   = '0;
            rx_rd   = '0;
            tx_wr   = '0;
            tx_rd   = '0;
            irq_en  = 1'b0;
            discard = 1'b0;
            led     = 1'b1;
            results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(step_rings(t_req'(i_s_tuser), i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = t_check_result'(i_m_tdata);
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat %h with nothing expected", $realtime, got);
                end else begin
                    want = results_due.pop_front();
                    if (want.rd_byte != got.rd_byte || want.empty != got.empty ||
                        want.sent != got.sent || want.sent_byte != got.sent_byte ||
                        want.irq != got.irq || want.led != got.led ||
                        want.dropped != got.dropped || want.pad != got.pad) begin
                        fails++;
                        if (fails <= 10) begin
                            $write("%0t: mismatch exp rd=%h empty=%b sent=%b sb=%h irq=%b",
                                   $realtime, want.rd_byte, want.empty, want.sent,
                                   want.sent_byte, want.irq);
                            $write(" led=%b drop=%b pad=%h", want.led, want.dropped,
                                   want.pad);
                            $write(" | got rd=%h empty=%b sent=%b sb=%h", got.rd_byte,
                                   got.empty, got.sent, got.sent_byte);
                            $display(" irq=%b led=%b drop=%b pad=%h", got.irq, got.led,
                                     got.dropped, got.pad);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// ===== test/tb.sv =====
// testbench top for the dual uart ring buffer: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb;
    import udrb_pkg::*;

    // cycles with no beat on either side before the run is called hung
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1625;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // data_byte[7:0]
    logic [1:0]  s_tuser  = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // read_byte[7:0], read_empty[8], send_valid[9],
                                  // send_byte[17:10], tx_irq_enabled[18],
                                  // activity_led[19], rx_dropped[20], zero[23:21]

    int   fail_count;
    int   pending_results;
    int   items_sent  = 0;
    int   stall_cycles = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;   // asks the result side for one long hold-off
    logic calm        = 1'b0;   // no random idling on either side while set

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uart_dual_ring_buffer_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    udrb_checker ring_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // result side: random stalls, one long hold-off on request, none while calm
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one event beat, maybe after a random gap, and wait until it is taken
    task automatic offer(input t_req kind, input t_byte data);
        if (!calm) begin
            while ($urandom_range(0, 99) < 13) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    initial begin
        int   seq_kind;
        int   n;
        logic held;
        logic paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // read and transmitter ready on empty rings, enable still off
        offer(REQ_READ, 8'hff);
        offer(REQ_TXRDY, 8'hff);
        // received zero, extremes and a pattern, popped back in order
        offer(REQ_RX, 8'h00);
        offer(REQ_RX, 8'hff);
        offer(REQ_RX, 8'ha5);
        offer(REQ_READ, 8'h00);
        offer(REQ_READ, 8'h00);
        offer(REQ_READ, 8'h00);
        offer(REQ_READ, 8'h5a);
        // short string, end mark enables, drain then enable drops
        offer(REQ_WRITE, 8'hff);
        offer(REQ_WRITE, 8'h01);
        offer(REQ_WRITE, 8'h80);
        offer(REQ_WRITE, END_MARK);
        offer(REQ_TXRDY, 8'h00);
        offer(REQ_TXRDY, 8'h00);
        offer(REQ_TXRDY, 8'h00);
        offer(REQ_TXRDY, 8'h00);
        offer(REQ_TXRDY, 8'h00);
        // end mark alone on an empty ring
        offer(REQ_WRITE, END_MARK);
        offer(REQ_TXRDY, 8'h7f);
        offer(REQ_TXRDY, 8'h7f);

        while (items_sent < ITEM_TARGET) begin
            seq_kind = $urandom_range(0, 9);
            case (seq_kind)
                0, 1: begin
                    // line bursts, long enough to overrun the receive ring
                    n = $urandom_range(1, 70);
                    repeat (n) offer(REQ_RX, t_byte'($urandom_range(0, 255)));
                end
                2: begin
                    n = $urandom_range(1, 70);
                    repeat (n) offer(REQ_READ, t_byte'($urandom_range(0, 255)));
                end
                3, 4: begin
                    // well-formed host string, sometimes past the ring size
                    n = $urandom_range(0, 80);
                    repeat (n) offer(REQ_WRITE, t_byte'($urandom_range(1, 255)));
                    offer(REQ_WRITE, END_MARK);
                end
                5: begin
                    n = $urandom_range(1, 80);
                    repeat (n) offer(REQ_TXRDY, t_byte'($urandom_range(0, 255)));
                end
                6: begin
                    // string that may overflow while enabled: space opens, discard holds
                    offer(REQ_WRITE, END_MARK);
                    n = $urandom_range(60, 75);
                    repeat (n) offer(REQ_WRITE, t_byte'($urandom_range(1, 255)));
                    n = $urandom_range(1, 4);
                    repeat (n) offer(REQ_TXRDY, t_byte'($urandom_range(0, 255)));
                    n = $urandom_range(1, 4);
                    repeat (n) offer(REQ_WRITE, t_byte'($urandom_range(1, 255)));
                    offer(REQ_WRITE, END_MARK);
                end
                7, 8: begin
                    // noise: any event, any byte
                    n = $urandom_range(1, 40);
                    repeat (n) offer(t_req'($urandom_range(0, 3)),
                                     t_byte'($urandom_range(0, 255)));
                end
                default: begin
                    n = $urandom_range(1, 60);
                    repeat (n) offer(($urandom_range(0, 1) != 0) ? REQ_RX : REQ_READ,
                                     t_byte'($urandom_range(0, 255)));
                end
            endcase

            // long hold-off on the result side while beats keep coming
            if (!held && items_sent >= 500) begin
                held     = 1'b1;
                hold_req <= 1'b1;
            end
            // sender goes quiet until every outstanding result is back
            if (!paused && items_sent >= 900) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                // let the checker record the beat just taken before the count is read
                @(posedge clk);
                while (pending_results != 0) @(posedge clk);
            end
            calm = (items_sent >= 1000) && (items_sent < 1300);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // drain, then wait for anything stray
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
